// ----- rtl/core/pplc_pkg.sv -----
// Shared types and constants for the packet deframer.
package pplc_pkg;

  typedef enum logic [1:0] {
    PH_SYNC = 2'd0,
    PH_LEN  = 2'd1,
    PH_PAY  = 2'd2,
    PH_HUNT = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    REG_PRE_FIRST  = 2'd0,
    REG_PRE_SECOND = 2'd1,
    REG_PRE_THIRD  = 2'd2,
    REG_MIN_LEN    = 2'd3
  } reg_idx_t;

  localparam logic [1:0] KIND_LEN  = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam logic [2:0] ERR_NONE  = 3'd0;
  localparam logic [2:0] ERR_LEN   = 3'd3;
  localparam logic [2:0] ERR_SUM   = 3'd4;

  localparam logic [1:0] PRE_LAST  = 2'd2;
  localparam logic [7:0] HDR_BYTES = 8'd4;
  localparam logic [7:0] LEN_FLOOR = 8'd5;

  localparam int unsigned ADDR_W = 4;

  typedef struct packed {
    logic [7:0] pre_first;
    logic [7:0] pre_second;
    logic [7:0] pre_third;
    logic [7:0] min_len;
  } cfg_t;

  typedef struct packed {
    logic [1:0] out_kind;
    logic [7:0] out_byte;
    logic [2:0] error_code;
    logic       close_buffer;
    logic       discard_buffer;
  } res_t;

endpackage

// ----- rtl/core/pplc_if.sv -----
// Request channel interfaces for received bytes and parser results.
interface pplc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface pplc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic [2:0] error_code;
  logic       close_buffer;
  logic       discard_buffer;

  modport source (output valid, output out_kind, output out_byte, output error_code,
                  output close_buffer, output discard_buffer, input ready);
  modport sink (input valid, input out_kind, input out_byte, input error_code,
                input close_buffer, input discard_buffer, output ready);
endinterface

// ----- rtl/core/pplc_cfg.sv -----
// APB configuration registers for preamble bytes and minimum length.
module pplc_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pplc_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output pplc_pkg::cfg_t               cfg
);

  pplc_pkg::cfg_t     cfg_r;
  pplc_pkg::cfg_t     cfg_nxt;
  pplc_pkg::reg_idx_t idx;
  logic               wr_en;
  logic [7:0]         rd_byte;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = pplc_pkg::reg_idx_t'(paddr[3:2]);

  always_comb begin
    cfg_nxt = cfg_r;
    rd_byte = cfg_r.pre_first;
    unique case (idx)
      pplc_pkg::REG_PRE_FIRST: begin
        rd_byte = cfg_r.pre_first;
        if (wr_en) cfg_nxt.pre_first = pwdata[7:0];
      end
      pplc_pkg::REG_PRE_SECOND: begin
        rd_byte = cfg_r.pre_second;
        if (wr_en) cfg_nxt.pre_second = pwdata[7:0];
      end
      pplc_pkg::REG_PRE_THIRD: begin
        rd_byte = cfg_r.pre_third;
        if (wr_en) cfg_nxt.pre_third = pwdata[7:0];
      end
      pplc_pkg::REG_MIN_LEN: begin
        rd_byte = cfg_r.min_len;
        if (wr_en) cfg_nxt.min_len = pwdata[7:0];
      end
      default: rd_byte = cfg_r.pre_first;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pre_first  <= 8'h03;
      cfg_r.pre_second <= 8'hEF;
      cfg_r.pre_third  <= 8'hAF;
      cfg_r.min_len    <= 8'd8;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign prdata = {24'd0, rd_byte};
  assign cfg    = cfg_r;

endmodule

// ----- rtl/core/pplc_fsm.sv -----
// Deframing state machine: phase, checksum, byte count and preamble match.
module pplc_fsm (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step,
  input  logic [7:0]     rx_byte,
  input  pplc_pkg::cfg_t cfg,
  output logic           res_vld,
  output pplc_pkg::res_t res
);

  pplc_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [7:0]       rem_r, rem_nxt;
  logic [1:0]       sync_idx_r, sync_idx_nxt;
  logic [1:0]       hunt_idx_r, hunt_idx_nxt;

  logic [7:0] sum_x;
  logic [7:0] rem_dec;
  logic [7:0] min_len;
  logic [1:0] cur_idx;
  logic [1:0] idx_inc;
  logic [7:0] expect_byte;
  logic       pre_hit;

  always_comb begin
    cur_idx = (phase_r == pplc_pkg::PH_HUNT) ? hunt_idx_r : sync_idx_r;
    if (cur_idx > pplc_pkg::PRE_LAST) cur_idx = 2'd0;
    case (cur_idx)
      2'd1:    expect_byte = cfg.pre_second;
      2'd2:    expect_byte = cfg.pre_third;
      default: expect_byte = cfg.pre_first;
    endcase
    pre_hit = (rx_byte == expect_byte);
    idx_inc = cur_idx + 2'd1;
    sum_x   = sum_r ^ rx_byte;
    rem_dec = rem_r - 8'd1;
    min_len = (cfg.min_len < pplc_pkg::LEN_FLOOR) ? pplc_pkg::LEN_FLOOR : cfg.min_len;
  end

  always_comb begin
    phase_nxt    = phase_r;
    sum_nxt      = sum_x;
    rem_nxt      = rem_r;
    sync_idx_nxt = sync_idx_r;
    hunt_idx_nxt = hunt_idx_r;
    res_vld      = 1'b0;
    res          = '0;
    unique case (phase_r)
      pplc_pkg::PH_SYNC: begin
        if (!pre_hit) begin
          sync_idx_nxt       = 2'd0;
          sum_nxt            = 8'd0;
          phase_nxt          = pplc_pkg::PH_HUNT;
          res_vld            = 1'b1;
          res.out_kind       = pplc_pkg::KIND_ERR;
          res.error_code     = {1'b0, cur_idx};
          res.close_buffer   = 1'b1;
        end else if (cur_idx == pplc_pkg::PRE_LAST) begin
          sync_idx_nxt = 2'd0;
          phase_nxt    = pplc_pkg::PH_LEN;
        end else begin
          sync_idx_nxt = idx_inc;
        end
      end
      pplc_pkg::PH_LEN: begin
        res_vld = 1'b1;
        if (rx_byte < min_len) begin
          sum_nxt          = 8'd0;
          phase_nxt        = pplc_pkg::PH_HUNT;
          res.out_kind     = pplc_pkg::KIND_ERR;
          res.error_code   = pplc_pkg::ERR_LEN;
          res.close_buffer = 1'b1;
        end else begin
          rem_nxt      = rx_byte - pplc_pkg::HDR_BYTES;
          phase_nxt    = pplc_pkg::PH_PAY;
          res.out_kind = pplc_pkg::KIND_LEN;
          res.out_byte = rx_byte - pplc_pkg::HDR_BYTES;
        end
      end
      pplc_pkg::PH_PAY: begin
        rem_nxt = rem_dec;
        res_vld = 1'b1;
        if (rem_dec != 8'd0) begin
          res.out_kind = pplc_pkg::KIND_DATA;
          res.out_byte = rx_byte;
        end else if (sum_x != 8'd0) begin
          sum_nxt            = 8'd0;
          phase_nxt          = pplc_pkg::PH_HUNT;
          res.out_kind       = pplc_pkg::KIND_ERR;
          res.error_code     = pplc_pkg::ERR_SUM;
          res.close_buffer   = 1'b1;
          res.discard_buffer = 1'b1;
        end else begin
          phase_nxt        = pplc_pkg::PH_SYNC;
          res.out_kind     = pplc_pkg::KIND_DATA;
          res.close_buffer = 1'b1;
        end
      end
      pplc_pkg::PH_HUNT: begin
        if (!pre_hit) begin
          hunt_idx_nxt = 2'd0;
          sum_nxt      = 8'd0;
        end else if (cur_idx == pplc_pkg::PRE_LAST) begin
          hunt_idx_nxt = 2'd0;
          phase_nxt    = pplc_pkg::PH_LEN;
        end else begin
          hunt_idx_nxt = idx_inc;
        end
      end
      default: phase_nxt = pplc_pkg::PH_SYNC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= pplc_pkg::PH_SYNC;
      sum_r      <= 8'd0;
      rem_r      <= 8'd0;
      sync_idx_r <= 2'd0;
      hunt_idx_r <= 2'd0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      sum_r      <= sum_nxt;
      rem_r      <= rem_nxt;
      sync_idx_r <= sync_idx_nxt;
      hunt_idx_r <= hunt_idx_nxt;
    end
  end

  a_hunt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    step && phase_r == pplc_pkg::PH_HUNT |-> !res_vld)
    else $error("result produced while hunting");

  a_err_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    step && res_vld && res.out_kind == pplc_pkg::KIND_ERR
    |=> phase_r == pplc_pkg::PH_HUNT && sum_r == 8'd0)
    else $error("error did not enter hunt with clear checksum");

  a_len_to_pay: assert property (@(posedge clk) disable iff (!rst_n)
    step && res_vld && res.out_kind == pplc_pkg::KIND_LEN
    |=> phase_r == pplc_pkg::PH_PAY && rem_r != 8'd0)
    else $error("length byte did not start payload");

  a_close_end: assert property (@(posedge clk) disable iff (!rst_n)
    step && res_vld && res.close_buffer && res.out_kind == pplc_pkg::KIND_DATA
    |=> phase_r == pplc_pkg::PH_SYNC)
    else $error("good packet end did not return to sync");

endmodule

// ----- rtl/core/preamble_length_checksum_packet_parser_unit.sv -----
// Top level of the serial packet deframer with preamble, length and XOR checksum.
// One received byte per request; a new byte can be taken every cycle. Each byte
// is held in the input register while the state machine updates the phase,
// checksum and byte count, and any result lands in the output register. Throughput
// is one byte per cycle while the result side takes results; a held result stalls
// input only once the input register is also occupied.
module preamble_length_checksum_packet_parser_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  pplc_in_if.sink                      in_ch,
  pplc_out_if.source                   out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pplc_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  pplc_pkg::cfg_t cfg;
  pplc_pkg::res_t res;
  pplc_pkg::res_t out_r;
  logic           res_vld;
  logic           in_vld_r, in_vld_nxt;
  logic [7:0]     in_byte_r;
  logic           out_vld_r, out_vld_nxt;
  logic           step;
  logic           in_take;

  pplc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pplc_fsm u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (in_byte_r),
    .cfg     (cfg),
    .res_vld (res_vld),
    .res     (res)
  );

  assign step        = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || step;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_take) begin
      in_vld_nxt = 1'b1;
    end else if (step) begin
      in_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (step && res_vld) begin
      out_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_ch.rx_byte;
    end
    if (step && res_vld) begin
      out_r <= res;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.out_kind       = out_r.out_kind;
  assign out_ch.out_byte       = out_r.out_byte;
  assign out_ch.error_code     = out_r.error_code;
  assign out_ch.close_buffer   = out_r.close_buffer;
  assign out_ch.discard_buffer = out_r.discard_buffer;

endmodule

// ----- sim/preamble_length_checksum_packet_parser_unit_tb.sv -----
// Self-checking testbench for the preamble, length and XOR checksum packet deframer.
module preamble_length_checksum_packet_parser_unit_tb;

  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 8;

  typedef struct {
    logic [7:0] data;
    bit         drain_first;
  } rx_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic       rx_valid = 1'b0;
  logic [7:0] rx_data = 8'h00;
  logic       res_ready = 1'b0;

  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [pplc_pkg::ADDR_W-1:0]   paddr = '0;
  logic [31:0]                   pwdata = '0;
  logic [31:0]                   prdata;
  logic                          pready;

  pplc_in_if  in_if ();
  pplc_out_if out_if ();

  assign in_if.valid   = rx_valid;
  assign in_if.rx_byte = rx_data;
  assign out_if.ready  = res_ready;

  preamble_length_checksum_packet_parser_unit uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // deframer shadow state and register copy
  pplc_pkg::cfg_t   cfg_shadow = '{pre_first: 8'h03, pre_second: 8'hEF, pre_third: 8'hAF,
                                   min_len: 8'd8};
  pplc_pkg::phase_t dfr_phase = pplc_pkg::PH_SYNC;
  logic [7:0] dfr_sum = 8'h00;
  logic [7:0] dfr_left = 8'h00;
  logic [1:0] dfr_sync_idx = 2'd0;
  logic [1:0] dfr_hunt_idx = 2'd0;

  rx_req_t        rx_stream [$];
  pplc_pkg::res_t due_results [$];
  pplc_pkg::res_t due_head;

  int   mismatches = 0;
  int   quiet_cycles = 0;
  logic rx_accepted = 1'b0;
  int   burst_left = 1;
  int   gap_left = 0;
  logic [7:0] stall_pat = 8'hFF;
  logic [5:0] pat_age = 6'd1;

  logic [7:0] opening [0:25] = '{
    8'hFF,
    8'h03, 8'hEF, 8'hAF, 8'h07,
    8'h03, 8'hAF,
    8'h03, 8'hEF, 8'hAF, 8'h09, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h4A,
    8'h03, 8'h00,
    8'h03, 8'hEF, 8'hAF, 8'h08, 8'h00, 8'hFF, 8'h5A, 8'h11
  };
  logic [7:0] short_floor [0:11] = '{
    8'h03, 8'hEF, 8'hAF, 8'h05, 8'h46,
    8'h03, 8'hEF, 8'h00,
    8'h03, 8'hEF, 8'hAF, 8'h04
  };

  function automatic logic [7:0] preamble_at(input logic [1:0] idx);
    if (idx == 2'd1) return cfg_shadow.pre_second;
    if (idx == pplc_pkg::PRE_LAST) return cfg_shadow.pre_third;
    return cfg_shadow.pre_first;
  endfunction

  function automatic logic [7:0] floor_len();
    return (cfg_shadow.min_len < pplc_pkg::LEN_FLOOR) ? pplc_pkg::LEN_FLOOR :
           cfg_shadow.min_len;
  endfunction

  task automatic flag_frame_error(input logic [2:0] code, input logic discard);
    dfr_sum = 8'h00;
    dfr_phase = pplc_pkg::PH_HUNT;
    due_results.push_back('{pplc_pkg::KIND_ERR, 8'h00, code, 1'b1, discard});
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    logic [1:0] idx;
    dfr_sum = dfr_sum ^ b;
    case (dfr_phase)
      pplc_pkg::PH_SYNC: begin
        idx = (dfr_sync_idx <= pplc_pkg::PRE_LAST) ? dfr_sync_idx : 2'd0;
        if (b != preamble_at(idx)) begin
          dfr_sync_idx = 2'd0;
          flag_frame_error({1'b0, idx}, 1'b0);
        end else if (idx == pplc_pkg::PRE_LAST) begin
          dfr_sync_idx = 2'd0;
          dfr_phase = pplc_pkg::PH_LEN;
        end else begin
          dfr_sync_idx = idx + 2'd1;
        end
      end
      pplc_pkg::PH_LEN: begin
        if (b < floor_len()) begin
          flag_frame_error(pplc_pkg::ERR_LEN, 1'b0);
        end else begin
          dfr_left = b - pplc_pkg::HDR_BYTES;
          dfr_phase = pplc_pkg::PH_PAY;
          due_results.push_back('{pplc_pkg::KIND_LEN, dfr_left, pplc_pkg::ERR_NONE,
                                  1'b0, 1'b0});
        end
      end
      pplc_pkg::PH_PAY: begin
        dfr_left = dfr_left - 8'd1;
        if (dfr_left != 8'd0) begin
          due_results.push_back('{pplc_pkg::KIND_DATA, b, pplc_pkg::ERR_NONE, 1'b0, 1'b0});
        end else if (dfr_sum != 8'h00) begin
          flag_frame_error(pplc_pkg::ERR_SUM, 1'b1);
        end else begin
          dfr_phase = pplc_pkg::PH_SYNC;
          due_results.push_back('{pplc_pkg::KIND_DATA, 8'h00, pplc_pkg::ERR_NONE,
                                  1'b1, 1'b0});
        end
      end
      default: begin
        idx = (dfr_hunt_idx <= pplc_pkg::PRE_LAST) ? dfr_hunt_idx : 2'd0;
        if (b == preamble_at(idx)) begin
          if (idx == pplc_pkg::PRE_LAST) begin
            dfr_hunt_idx = 2'd0;
            dfr_phase = pplc_pkg::PH_LEN;
          end else begin
            dfr_hunt_idx = idx + 2'd1;
          end
        end else begin
          dfr_hunt_idx = 2'd0;
          dfr_sum = 8'h00;
        end
      end
    endcase
  endtask

  // sample both channels and the register port
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_accepted <= 1'b0;
    end else begin
      rx_accepted <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready) begin
        deframe_byte(in_if.rx_byte);
      end
      if (out_if.valid && out_if.ready) begin
        if (due_results.size() == 0) begin
          $error("result with no request pending: out_kind %0d out_byte %0h",
                 out_if.out_kind, out_if.out_byte);
          mismatches++;
        end else begin
          due_head = due_results.pop_front();
          if (out_if.out_kind !== due_head.out_kind) begin
            $error("out_kind expected %0d got %0d", due_head.out_kind, out_if.out_kind);
            mismatches++;
          end
          if (out_if.out_byte !== due_head.out_byte) begin
            $error("out_byte expected %0h got %0h", due_head.out_byte, out_if.out_byte);
            mismatches++;
          end
          if (out_if.error_code !== due_head.error_code) begin
            $error("error_code expected %0d got %0d", due_head.error_code,
                   out_if.error_code);
            mismatches++;
          end
          if (out_if.close_buffer !== due_head.close_buffer) begin
            $error("close_buffer expected %0b got %0b", due_head.close_buffer,
                   out_if.close_buffer);
            mismatches++;
          end
          if (out_if.discard_buffer !== due_head.discard_buffer) begin
            $error("discard_buffer expected %0b got %0b", due_head.discard_buffer,
                   out_if.discard_buffer);
            mismatches++;
          end
        end
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (psel && penable && pready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // byte sender: bursts with random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      rx_valid <= 1'b0;
    end else if (rx_valid && !rx_accepted) begin
      rx_valid <= 1'b1;
    end else if (gap_left != 0) begin
      rx_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (rx_stream.size() != 0 &&
                 (!rx_stream[0].drain_first || due_results.size() == 0)) begin
      rx_valid <= 1'b1;
      rx_data <= rx_stream[0].data;
      rx_stream.pop_front();
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 24);
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      rx_valid <= 1'b0;
    end
  end

  // result receiver: rotate a stall pattern, reload it now and then
  always @(negedge clk) begin
    if (!rst_n) begin
      res_ready <= 1'b0;
    end else begin
      res_ready <= stall_pat[0];
      stall_pat <= (pat_age == 6'd0) ?
                   (($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom_range(1, 255))) :
                   {stall_pat[0], stall_pat[7:1]};
      pat_age <= pat_age + 6'd1;
    end
  end

  task automatic reg_write(input pplc_pkg::reg_idx_t idx, input logic [7:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'h0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      pplc_pkg::REG_PRE_FIRST:  cfg_shadow.pre_first = value;
      pplc_pkg::REG_PRE_SECOND: cfg_shadow.pre_second = value;
      pplc_pkg::REG_PRE_THIRD:  cfg_shadow.pre_third = value;
      default:                  cfg_shadow.min_len = value;
    endcase
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[7:0] !== value) begin
      $error("register %0d readback expected %0h got %0h", idx, value, prdata[7:0]);
      mismatches++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic load_config(input logic [7:0] p0, input logic [7:0] p1,
                             input logic [7:0] p2, input logic [7:0] min_len);
    reg_write(pplc_pkg::REG_PRE_FIRST, p0);
    reg_write(pplc_pkg::REG_PRE_SECOND, p1);
    reg_write(pplc_pkg::REG_PRE_THIRD, p2);
    reg_write(pplc_pkg::REG_MIN_LEN, min_len);
  endtask

  task automatic queue_byte(input logic [7:0] b, input bit drain);
    rx_stream.push_back('{b, drain});
  endtask

  // whole packet; corrupt one preamble byte or the checksum on request
  task automatic queue_packet(input int len, input int bad_pre, input logic [7:0] sum_flip,
                              input bit drain);
    logic [7:0] acc;
    logic [7:0] b;
    acc = 8'h00;
    for (int i = 0; i < 3; i++) begin
      b = preamble_at(i[1:0]);
      if (i == bad_pre) b = b ^ 8'($urandom_range(1, 255));
      queue_byte(b, drain && (i == 0));
      acc = acc ^ b;
    end
    queue_byte(len[7:0], 1'b0);
    acc = acc ^ len[7:0];
    if (len >= 5) begin
      for (int i = 0; i < len - 5; i++) begin
        b = 8'($urandom_range(0, 255));
        queue_byte(b, 1'b0);
        acc = acc ^ b;
      end
      queue_byte(acc ^ sum_flip, 1'b0);
    end
  endtask

  function automatic int pick_len();
    int lo;
    lo = floor_len();
    if ($urandom_range(0, 39) == 0) return $urandom_range(lo, 255);
    return lo + $urandom_range(0, (255 - lo < 10) ? 255 - lo : 10);
  endfunction

  task automatic random_traffic(input int budget);
    int pick;
    int n;
    bit mark;
    bit drained;
    drained = 1'b0;
    while (rx_stream.size() < budget) begin
      pick = $urandom_range(0, 99);
      mark = !drained && (rx_stream.size() >= budget / 2);
      if (mark) drained = 1'b1;
      if (pick < 70) begin
        queue_packet(pick_len(), -1, 8'h00, mark);
      end else if (pick < 78) begin
        queue_packet(pick_len(), -1, 8'($urandom_range(1, 255)), mark);
      end else if (pick < 85) begin
        queue_packet(pick_len(), $urandom_range(0, 2), 8'h00, mark);
      end else if (pick < 91) begin
        queue_packet($urandom_range(0, floor_len() - 1), -1, 8'h00, mark);
      end else begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) queue_byte(8'($urandom_range(0, 255)), mark && (i == 0));
      end
    end
  endtask

  // hold until every request is taken and answered, then let the pipeline drain
  task automatic settle();
    while (!(rx_stream.size() == 0 && !rx_valid && due_results.size() == 0))
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    while (quiet_cycles < IDLE_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    foreach (opening[i]) queue_byte(opening[i], 1'b0);
    settle();
    load_config(8'h03, 8'hEF, 8'hAF, 8'h00);
    foreach (short_floor[i]) queue_byte(short_floor[i], 1'b0);
    settle();
    for (int p = 0; p < 7; p++) begin
      case (p)
        0: load_config(8'h03, 8'hEF, 8'hAF, 8'd8);
        1: load_config(8'h00, 8'hFF, 8'h00, 8'd5);
        2: load_config(8'hFF, 8'hFF, 8'hFF, 8'd255);
        3: load_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 4)));
        default: load_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)), 8'($urandom_range(5, 30)));
      endcase
      random_traffic((p == 2) ? 100 : 170);
      settle();
    end
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
